// ----- hw/rtl/equal_spaced_multitap_delay_assert.svh -----
// Assertion macros used by the multi-tap delay RTL.
`ifndef EQUAL_SPACED_MULTITAP_DELAY_ASSERT_SVH
`define EQUAL_SPACED_MULTITAP_DELAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ESMD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESMD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/esmd_pkg.sv -----
// Shared widths, register indexes and types of the multi-tap delay.
package esmd_pkg;

    localparam int SPAN_W    = 12;          // span register width
    localparam int TAPC_W    = 5;           // tap count register width
    localparam int DIV_W     = TAPC_W + 1;  // divisor width, holds twice the copy count
    localparam int CFG_W     = 12;          // widest register
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPAN   = 2'd0,
        REG_TAPS   = 2'd1,
        REG_INVERT = 2'd2
    } esmd_reg_idx_t;

    // Divider status seen by the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } esmd_div_stat_t;

    // Running tap offset: quotient and remainder of (2*span*i + c) / (2*c).
    typedef struct packed {
        logic [SPAN_W-1:0] off;
        logic [DIV_W-1:0]  rem;
    } esmd_off_t;

endpackage

// ----- hw/rtl/esmd_div.sv -----
// Radix-4 restoring divider with a narrow divisor, two quotient bits per cycle.
module esmd_div
    import esmd_pkg::*;
#(
    parameter int DIVIDEND_W = 30
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIV_W-1:0]      divisor,
    output esmd_div_stat_t        stat,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIV_W-1:0]      remainder
);

    localparam int STEPS = DIVIDEND_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVIDEND_W-1:0] acc_reg, acc_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      dvs_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIV_W+1:0] part;
    logic [DIV_W+1:0] d1, d2, d3;
    logic [DIV_W+1:0] diff;
    logic [1:0]       digit;

    always_comb begin
        d1   = {2'b00, dvs_reg};
        d2   = {1'b0, dvs_reg, 1'b0};
        d3   = d1 + d2;
        part = {rem_reg, acc_reg[DIVIDEND_W-1 -: 2]};
        if (part >= d3) begin
            digit = 2'd3;
            diff  = part - d3;
        end else if (part >= d2) begin
            digit = 2'd2;
            diff  = part - d2;
        end else if (part >= d1) begin
            digit = 2'd1;
            diff  = part - d1;
        end else begin
            digit = 2'd0;
            diff  = part;
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {acc_reg[DIVIDEND_W-3:0], digit};
            rem_next = diff[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign stat      = '{busy: busy_reg, done: done_reg};
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/equal_spaced_multitap_delay.sv -----
// Equal-spaced multi-tap delay: sample memory, tap sequencer and shared divider.
// Passing through (span not yet exceeded, or one copy), the input goes straight to the
// output; otherwise one memory read per delayed tap, then the radix-4 divider that
// applies the 1/copies gain. An output stall holds the result. A new sample is taken
// only once the last is in the output register. A span or tap count write holds s_ready
// low until the tap step is recomputed. Reset clears pointer, fill count, span, invert.
`include "equal_spaced_multitap_delay_assert.svh"

module equal_spaced_multitap_delay
    import esmd_pkg::*;
#(
    parameter int DELAY_DEPTH = 4096,
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int FW  = $clog2(DELAY_DEPTH + 1);
    localparam int IW  = ((AW > SPAN_W) ? AW : SPAN_W) + 1;
    localparam int CW  = (FW > SPAN_W) ? FW : SPAN_W;
    localparam int SW  = SAMPLE_BITS + TAPC_W + 1;     // tap sum, signed
    localparam int DW  = SW + (SW % 2);                // divider dividend, even
    localparam logic signed [DW:0] RES_LO = -((DW+1)'(1) << (SAMPLE_BITS - 1));
    localparam logic signed [DW:0] RES_HI = ((DW+1)'(1) << (SAMPLE_BITS - 1)) - (DW+1)'(1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CDIV  = 7'b0000010,
        ST_TAPS  = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_OLOAD = 7'b0010000,
        ST_ODIV  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    function automatic esmd_off_t off_step(input esmd_off_t cur,
                                           input logic [SPAN_W-1:0] q,
                                           input logic [DIV_W-1:0] r,
                                           input logic [DIV_W-1:0] two_c);
        logic [DIV_W:0] t;
        esmd_off_t      nxt;
        t = {1'b0, cur.rem} + {r, 1'b0};
        if (t >= {1'b0, two_c}) begin
            nxt.rem = DIV_W'(t - {1'b0, two_c});
            nxt.off = cur.off + q + SPAN_W'(1);
        end else begin
            nxt.rem = t[DIV_W-1:0];
            nxt.off = cur.off + q;
        end
        return nxt;
    endfunction

    // Delay memory
    logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
    logic                          mem_we;
    logic [AW-1:0]                 rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    // Control and datapath registers
    state_t                        state_reg, state_next;
    logic [SPAN_W-1:0]             span_reg, span_next;
    logic [TAPC_W-1:0]             taps_reg, taps_next;
    logic                          inv_reg, inv_next;
    logic                          dirty_reg, dirty_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [FW-1:0]                 fill_reg, fill_next;
    logic [SPAN_W-1:0]             qstep_reg, qstep_next;
    logic [DIV_W-1:0]              rstep_reg, rstep_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic                          rd_inv_reg, rd_inv_next;
    logic                          m_valid_reg, m_valid_next;

    logic [AW-1:0]                 wpc_reg, wpc_next;
    esmd_off_t                     off_reg, off_next;
    logic [TAPC_W-1:0]             tap_i_reg, tap_i_next;
    logic signed [SW-1:0]          sum_reg, sum_next;
    logic                          neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] res_reg, res_next;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= s_sample_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Divider
    logic                  div_start;
    logic [DW-1:0]         div_dividend;
    logic [DIV_W-1:0]      div_divisor;
    esmd_div_stat_t        div_stat;
    logic [DW-1:0]         div_quot;
    logic [DIV_W-1:0]      div_rem;

    esmd_div #(
        .DIVIDEND_W (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Effective copy count
    logic [TAPC_W-1:0] copies;
    logic [DIV_W-1:0]  two_c;

    always_comb begin
        if (taps_reg == '0) begin
            copies = TAPC_W'(1);
        end else if (32'(taps_reg) > MAX_TAPS) begin
            copies = TAPC_W'(MAX_TAPS);
        end else begin
            copies = taps_reg;
        end
        two_c = {copies, 1'b0};
    end

    // Tap address: current write slot minus the clamped offset, wrapped
    logic [IW-1:0]   off_c;
    logic [IW-1:0]   wp_e;
    logic [IW-1:0]   idx_diff;
    logic            off_lt_fill;

    always_comb begin
        off_c = IW'(off_reg.off);
        if (off_c > IW'(DELAY_DEPTH - 1)) begin
            off_c = IW'(DELAY_DEPTH - 1);
        end
        wp_e     = IW'(wpc_reg);
        idx_diff = wp_e - off_c;
        if (wp_e < off_c) begin
            idx_diff = idx_diff + IW'(DELAY_DEPTH);
        end
        rd_addr     = idx_diff[AW-1:0];
        off_lt_fill = (off_c < IW'(fill_reg));
    end

    // Sum magnitude for rounding: 2*|sum| + c over 2*c
    logic [SW-1:0]         sum_mag;
    logic [SW-1:0]         div_num;
    logic signed [DW:0]    qs;
    logic signed [DW:0]    res_full;
    logic signed [SW-1:0]  tap_ext;
    esmd_off_t             off_init;

    always_comb begin
        sum_mag  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        div_num  = {sum_mag[SW-2:0], 1'b0} + SW'(copies);
        qs       = $signed({1'b0, div_quot});
        res_full = neg_reg ? -qs : qs;
        tap_ext  = SW'(rd_data_reg);
        off_init = '{off: '0, rem: DIV_W'(copies)};
    end

    assign s_ready = (state_reg == ST_IDLE) && !dirty_reg;

    always_comb begin
        state_next    = state_reg;
        span_next     = span_reg;
        taps_next     = taps_reg;
        inv_next      = inv_reg;
        dirty_next    = dirty_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        qstep_next    = qstep_reg;
        rstep_next    = rstep_reg;
        rd_valid_next = 1'b0;
        rd_inv_next   = rd_inv_reg;
        m_valid_next  = m_valid_reg;
        wpc_next      = wpc_reg;
        off_next      = off_reg;
        tap_i_next    = tap_i_reg;
        sum_next      = sum_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        div_dividend  = DW'(span_reg);
        div_divisor   = DIV_W'(copies);

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SPAN: begin
                    span_next  = cfg_data[SPAN_W-1:0];
                    dirty_next = 1'b1;
                end
                REG_TAPS: begin
                    taps_next  = cfg_data[TAPC_W-1:0];
                    dirty_next = 1'b1;
                end
                REG_INVERT: begin
                    inv_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Read data arriving from the memory joins the sum
        if (rd_valid_reg) begin
            sum_next = rd_inv_reg ? sum_reg - tap_ext : sum_reg + tap_ext;
        end

        case (state_reg)
            ST_IDLE: begin
                if (dirty_reg) begin
                    div_start  = 1'b1;
                    dirty_next = cfg_wr_en && (cfg_index == REG_SPAN || cfg_index == REG_TAPS);
                    state_next = ST_CDIV;
                end else if (s_valid) begin
                    mem_we    = 1'b1;
                    wpc_next  = wp_reg;
                    wp_next   = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    fill_next = (fill_reg == FW'(DELAY_DEPTH)) ? fill_reg : fill_reg + FW'(1);
                    sum_next  = SW'(s_sample_in);
                    res_next  = s_sample_in;
                    off_next  = off_step(off_init, qstep_reg, rstep_reg, two_c);
                    tap_i_next = TAPC_W'(1);
                    if (CW'(fill_next) <= CW'(span_reg) || copies == TAPC_W'(1)) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_TAPS;
                    end
                end
            end
            ST_CDIV: begin
                if (div_stat.done) begin
                    qstep_next = div_quot[SPAN_W-1:0];
                    rstep_next = div_rem;
                    state_next = ST_IDLE;
                end
            end
            ST_TAPS: begin
                rd_valid_next = 1'b1;
                rd_inv_next   = inv_reg && tap_i_reg[0];
                off_next      = off_step(off_reg, qstep_reg, rstep_reg, two_c);
                tap_i_next    = tap_i_reg + TAPC_W'(1);
                if (tap_i_reg == copies - TAPC_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_OLOAD;
            end
            ST_OLOAD: begin
                div_start    = 1'b1;
                div_dividend = DW'(div_num);
                div_divisor  = two_c;
                neg_next     = sum_reg[SW-1];
                state_next   = ST_ODIV;
            end
            ST_ODIV: begin
                if (div_stat.done) begin
                    if (res_full < RES_LO) begin
                        res_next = SAMPLE_BITS'(RES_LO);
                    end else if (res_full > RES_HI) begin
                        res_next = SAMPLE_BITS'(RES_HI);
                    end else begin
                        res_next = SAMPLE_BITS'(res_full);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            span_reg     <= '0;
            taps_reg     <= TAPC_W'(1);
            inv_reg      <= 1'b0;
            dirty_reg    <= 1'b0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            qstep_reg    <= '0;
            rstep_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_inv_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            span_reg     <= span_next;
            taps_reg     <= taps_next;
            inv_reg      <= inv_next;
            dirty_reg    <= dirty_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            qstep_reg    <= qstep_next;
            rstep_reg    <= rstep_next;
            rd_valid_reg <= rd_valid_next;
            rd_inv_reg   <= rd_inv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wpc_reg   <= wpc_next;
        off_reg   <= off_next;
        tap_i_reg <= tap_i_next;
        sum_reg   <= sum_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;

    `ESMD_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second transfer while an item is in flight")
    `ESMD_ASSERT_IMP(a_div_idle, aclk, aresetn, div_start, !div_stat.busy, "divider restarted while busy")
    `ESMD_ASSERT_IMP(a_tap_written, aclk, aresetn, state_reg == ST_TAPS, off_lt_fill, "tap reaches an unwritten sample")
    `ESMD_ASSERT_IMP(a_rd_window, aclk, aresetn, rd_valid_reg, state_reg == ST_TAPS || state_reg == ST_DRAIN, "tap data outside accumulation")

endmodule
